FILE: hdl/color_channel_format_converter_top_macros.svh
// assertion macros for the color channel format converter
// expects clk and rst_n in the scope where a macro is used
`ifndef COLOR_CHANNEL_FORMAT_CONVERTER_TOP_MACROS_SVH
`define COLOR_CHANNEL_FORMAT_CONVERTER_TOP_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define CCFC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccfc assertion failed");

// condition that must never hold outside reset
`define CCFC_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ccfc forbidden condition seen");

`endif

FILE: hdl/ccfc_pkg.sv
// shared types and constants of the color channel format converter
// no dependencies
`default_nettype none

package ccfc_pkg;

    // channel format codes, code three is unused
    localparam logic [1:0] FMT_U8  = 2'd0;
    localparam logic [1:0] FMT_U16 = 2'd1;
    localparam logic [1:0] FMT_F32 = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_SOURCE = 2'd0;
    localparam logic [1:0] REG_TARGET = 2'd1;

    // float constants as bit patterns
    localparam logic [31:0] F32_ONE = 32'h3F80_0000;

    // which unit produces the result of an item
    typedef enum logic [1:0] {
        ROUTE_INT = 2'd0,
        ROUTE_F2U = 2'd1,
        ROUTE_U2F = 2'd2
    } route_t;

endpackage

`default_nettype wire

FILE: hdl/ccfc_f2u.sv
// float32 to unorm8 or unorm16, three register stages
// depends on ccfc_pkg
`default_nettype none

module ccfc_f2u (
    input  wire logic        clk,
    input  wire logic [31:0] value,
    input  wire logic        is16,
    output logic      [31:0] result
);
    import ccfc_pkg::*;

    logic        is16_1_reg, is16_2_reg;
    logic        zero_1_reg, zero_2_reg, zero_next;
    logic        one_1_reg, one_2_reg, one_next;
    logic [39:0] prod_reg, prod_next;
    logic [7:0]  shift_reg, shift_next;
    logic [24:0] rnd_reg, rnd_next;
    logic [7:0]  sh_reg, sh_next;
    logic [31:0] result_reg, result_next;
    logic [7:0]  expo;
    logic [22:0] frac;
    logic [15:0] scale;
    logic [4:0]  drop;
    logic [4:0]  drop_m1;
    logic [39:0] shifted;
    logic        sticky;

    // stage 1: classify and scale the significand
    always_comb
    begin
        expo       = value[30:23];
        frac       = value[22:0];
        zero_next  = ((&expo) && (|frac)) || value[31] || (expo == 8'd0);
        one_next   = !zero_next && (expo >= 8'd127);
        scale      = is16 ? 16'hFFFF : 16'h00FF;
        prod_next  = 40'({1'b1, frac}) * 40'(scale);
        shift_next = 8'd150 - expo;
    end

    // stage 2: round the product to 24 significant bits
    always_comb
    begin
        if (is16_1_reg)
        begin
            drop = prod_reg[39] ? 5'd16 : 5'd15;
        end
        else
        begin
            drop = prod_reg[31] ? 5'd8 : 5'd7;
        end
        drop_m1  = drop - 5'd1;
        shifted  = prod_reg >> drop_m1;
        sticky   = |(prod_reg & ((40'd1 << drop_m1) - 40'd1));
        rnd_next = {1'b0, shifted[24:1]}
                   + {24'd0, shifted[0] & (sticky | shifted[1])};
        sh_next  = shift_reg - {3'd0, drop};
    end

    // stage 3: truncate toward zero, apply clamps
    always_comb
    begin
        if (zero_2_reg)
        begin
            result_next = 32'd0;
        end
        else if (one_2_reg)
        begin
            result_next = is16_2_reg ? 32'h0000_FFFF : 32'h0000_00FF;
        end
        else if (sh_reg >= 8'd25)
        begin
            result_next = 32'd0;
        end
        else
        begin
            result_next = 32'(rnd_reg >> sh_reg);
        end
    end

    // pipeline registers, payload only
    always_ff @(posedge clk)
    begin
        is16_1_reg <= is16;
        zero_1_reg <= zero_next;
        one_1_reg  <= one_next;
        prod_reg   <= prod_next;
        shift_reg  <= shift_next;
        is16_2_reg <= is16_1_reg;
        zero_2_reg <= zero_1_reg;
        one_2_reg  <= one_1_reg;
        rnd_reg    <= rnd_next;
        sh_reg     <= sh_next;
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

`default_nettype wire

FILE: hdl/ccfc_u2f.sv
// unorm8 or unorm16 to float32, three register stages
// depends on ccfc_pkg
`default_nettype none

module ccfc_u2f (
    input  wire logic        clk,
    input  wire logic [15:0] value,
    input  wire logic        is16,
    output logic      [31:0] result
);
    import ccfc_pkg::*;

    logic [15:0] pat_reg, pat_next;
    logic [3:0]  lz_reg, lz_next;
    logic        zero_1_reg, zero_2_reg, zero_next;
    logic        full_1_reg, full_2_reg, full_next;
    logic [22:0] frac_reg, frac_next;
    logic        guard_reg, guard_next;
    logic [7:0]  expo_reg, expo_next;
    logic [31:0] result_reg, result_next;
    logic        found;
    logic [63:0] window;

    // stage 1: repeat the pattern to 16 bits, count leading zeros
    always_comb
    begin
        pat_next  = is16 ? value : {value[7:0], value[7:0]};
        zero_next = is16 ? (value == 16'd0) : (value[7:0] == 8'd0);
        full_next = is16 ? (&value) : (&value[7:0]);
        lz_next   = 4'd0;
        found     = 1'b0;
        for (int i = 15; i >= 0; i--)
        begin
            if (!found && pat_next[i])
            begin
                lz_next = 4'(15 - i);
                found   = 1'b1;
            end
        end
    end

    // stage 2: the quotient is the repeating pattern, normalize it
    always_comb
    begin
        window     = {pat_reg, pat_reg, pat_reg, pat_reg} << lz_reg;
        frac_next  = window[62:40];
        guard_next = window[39];
        expo_next  = 8'd126 - {4'd0, lz_reg};
    end

    // stage 3: round up on guard, the tail is never zero
    always_comb
    begin
        if (zero_2_reg)
        begin
            result_next = 32'd0;
        end
        else if (full_2_reg)
        begin
            result_next = F32_ONE;
        end
        else
        begin
            result_next = {1'b0, expo_reg, frac_reg} + {31'd0, guard_reg};
        end
    end

    // pipeline registers, payload only
    always_ff @(posedge clk)
    begin
        pat_reg    <= pat_next;
        lz_reg     <= lz_next;
        zero_1_reg <= zero_next;
        full_1_reg <= full_next;
        frac_reg   <= frac_next;
        guard_reg  <= guard_next;
        expo_reg   <= expo_next;
        zero_2_reg <= zero_1_reg;
        full_2_reg <= full_1_reg;
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

`default_nettype wire

FILE: hdl/ccfc_int.sv
// integer conversions, pass through and unused codes, three stages
// depends on ccfc_pkg
`default_nettype none

module ccfc_int (
    input  wire logic        clk,
    input  wire logic [31:0] value,
    input  wire logic [1:0]  src,
    input  wire logic [1:0]  dst,
    output logic      [31:0] result
);
    import ccfc_pkg::*;

    logic [32:0] quot_reg, quot_next;
    logic [31:0] value_reg;
    logic [1:0]  src_reg, dst_reg;
    logic [31:0] mid_reg, mid_next;
    logic [31:0] result_reg;

    // stage 1: floor of n / 257 by reciprocal multiply
    assign quot_next = 33'(value[15:0]) * 33'd65281;

    // stage 2: select by format pair
    always_comb
    begin
        mid_next = 32'd0;
        if (src_reg == FMT_U8 && dst_reg == FMT_U8)
        begin
            mid_next = {24'd0, value_reg[7:0]};
        end
        else if (src_reg == FMT_U8 && dst_reg == FMT_U16)
        begin
            mid_next = {16'd0, value_reg[7:0], value_reg[7:0]};
        end
        else if (src_reg == FMT_U16 && dst_reg == FMT_U8)
        begin
            mid_next = {24'd0, quot_reg[31:24]};
        end
        else if (src_reg == FMT_U16 && dst_reg == FMT_U16)
        begin
            mid_next = {16'd0, value_reg[15:0]};
        end
        else if (src_reg == FMT_F32 && dst_reg == FMT_F32)
        begin
            mid_next = value_reg;
        end
    end

    // pipeline registers, payload only
    always_ff @(posedge clk)
    begin
        quot_reg   <= quot_next;
        value_reg  <= value;
        src_reg    <= src;
        dst_reg    <= dst;
        mid_reg    <= mid_next;
        result_reg <= mid_reg;
    end

    assign result = result_reg;

endmodule

`default_nettype wire

FILE: hdl/color_channel_format_converter_top.sv
// top level of the color channel format converter
// depends on ccfc_pkg, ccfc_f2u, ccfc_u2f, ccfc_int and the macro header
`default_nettype none

// Converts one color channel value per clock between unorm8, unorm16 and
// float32 bit patterns. A value is taken on every cycle with start high
// (busy is always low) and its result appears with done once it has
// passed the three register stages of its conversion unit, one result
// per cycle. done lasts one cycle and the receiver cannot hold it off.
// Formats must be written through the always-ready cfg port only while
// no conversion is in flight; the block itself does not enforce this.
`include "color_channel_format_converter_top_macros.svh"

module color_channel_format_converter_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] channel_value,
    input  wire logic [1:0]  channel_index,
    output logic             done,
    output logic      [31:0] converted_value,
    output logic      [1:0]  channel_tag,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [1:0]  cfg_data
);
    import ccfc_pkg::*;

    logic [1:0]  source_format_reg;
    logic [1:0]  target_format_reg;
    logic [2:0]  valid_reg;
    logic [1:0]  tag_reg [3];
    route_t      route_reg [3];
    route_t      route_next;
    logic        accept;
    logic [31:0] f2u_result, u2f_result, int_result;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_format_reg <= FMT_U8;
            target_format_reg <= FMT_U8;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_SOURCE)
            begin
                source_format_reg <= cfg_data;
            end
            else if (cfg_index == REG_TARGET)
            begin
                target_format_reg <= cfg_data;
            end
        end
    end

    // pick the unit for this format pair
    always_comb
    begin
        route_next = ROUTE_INT;
        if (source_format_reg == FMT_F32
            && (target_format_reg == FMT_U8 || target_format_reg == FMT_U16))
        begin
            route_next = ROUTE_F2U;
        end
        else if ((source_format_reg == FMT_U8 || source_format_reg == FMT_U16)
                 && target_format_reg == FMT_F32)
        begin
            route_next = ROUTE_U2F;
        end
    end

    // valid bits travel with each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 3'b000;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], accept};
        end
    end

    // tag and route side band
    always_ff @(posedge clk)
    begin
        tag_reg[0]   <= channel_index;
        tag_reg[1]   <= tag_reg[0];
        tag_reg[2]   <= tag_reg[1];
        route_reg[0] <= route_next;
        route_reg[1] <= route_reg[0];
        route_reg[2] <= route_reg[1];
    end

    // conversion units
    ccfc_f2u u_f2u (
        .clk    (clk),
        .value  (channel_value),
        .is16   (target_format_reg == FMT_U16),
        .result (f2u_result)
    );

    ccfc_u2f u_u2f (
        .clk    (clk),
        .value  (channel_value[15:0]),
        .is16   (source_format_reg == FMT_U16),
        .result (u2f_result)
    );

    ccfc_int u_int (
        .clk    (clk),
        .value  (channel_value),
        .src    (source_format_reg),
        .dst    (target_format_reg),
        .result (int_result)
    );

    // result select
    always_comb
    begin
        unique case (route_reg[2])
            ROUTE_F2U: converted_value = f2u_result;
            ROUTE_U2F: converted_value = u2f_result;
            ROUTE_INT: converted_value = int_result;
            default:   converted_value = 32'd0;
        endcase
    end

    assign done        = valid_reg[2];
    assign channel_tag = tag_reg[2];

    // checks
    `CCFC_ASSERT_IMPL(a_tag_follows, done, channel_tag == $past(channel_index, 3))
    `CCFC_ASSERT_IMPL(a_done_from_start, done, $past(start, 3))
    `CCFC_ASSERT_NEVER(a_u2f_positive, done && route_reg[2] == ROUTE_U2F && converted_value[31])

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// self-checking testbench of color_channel_format_converter_top
// depends on ccfc_pkg and the converter rtl
`default_nettype none

module testbench;
    import ccfc_pkg::*;

    localparam logic [1:0] FMT_UNUSED = 2'd3;
    localparam int         SETTLE_CYCLES = 6;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] channel_value;
    logic [1:0]  channel_index;
    logic        done;
    logic [31:0] converted_value;
    logic [1:0]  channel_tag;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [1:0]  cfg_data;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  tag;
    } channel_result_t;

    typedef struct {
        logic [1:0]  src;
        logic [1:0]  dst;
        logic [31:0] value;
        logic [1:0]  index;
        bit          typed;
        logic [31:0] result;
    } directed_row_t;

    channel_result_t pending_results[$];
    logic [1:0]      cur_source;
    logic [1:0]      cur_target;
    int              error_count;
    bit              no_idle;

    color_channel_format_converter_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .channel_value   (channel_value),
        .channel_index   (channel_index),
        .done            (done),
        .converted_value (converted_value),
        .channel_tag     (channel_tag),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("color_channel_format_converter_top regression: fail");
        $finish;
    end

    // unorm to float: n / scale rounded to nearest even in single precision
    function automatic logic [31:0] unorm_to_single(logic [31:0] n, logic [31:0] scale);
        logic [63:0] quo;
        logic [63:0] rem;
        int          k;
        if (n == 0)
            return 32'h0;
        for (k = 0; k < 60; k++)
        begin
            quo = (64'(n) << k) / scale;
            if (quo >= 64'h80_0000)
                break;
        end
        rem = (64'(n) << k) % scale;
        if (2 * rem > 64'(scale) || (2 * rem == 64'(scale) && quo[0]))
            quo = quo + 1;
        if (quo == 64'h100_0000)
        begin
            quo = 64'h80_0000;
            k = k - 1;
        end
        return {1'b0, 8'(150 - k), quo[22:0]};
    endfunction

    // float to unorm: clamp to [0,1], scale with single rounding, truncate
    function automatic logic [31:0] single_to_unorm(logic [31:0] bits, logic [31:0] scale);
        logic [7:0]  expo;
        logic [23:0] mant;
        logic [63:0] prod;
        logic [63:0] kept;
        logic [63:0] rest;
        logic [63:0] half;
        int          shift;
        int          len;
        int          drop;
        expo = bits[30:23];
        if (expo == 8'hFF && bits[22:0] != 0)
            return 32'h0;
        if (bits[31] || bits[30:0] == 0)
            return 32'h0;
        if (bits[30:0] > F32_ONE)
            return scale;
        mant  = (expo == 0) ? {1'b0, bits[22:0]} : {1'b1, bits[22:0]};
        shift = ((expo == 0) ? 1 : int'(expo)) - 150;
        prod  = 64'(mant) * 64'(scale);
        len = 0;
        for (int i = 0; i < 64; i++)
            if (prod[i])
                len = i + 1;
        drop = (len > 24) ? len - 24 : 0;
        if (drop > 0)
        begin
            kept = prod >> drop;
            rest = prod & ((64'd1 << drop) - 1);
            half = 64'd1 << (drop - 1);
            if (rest > half || (rest == half && kept[0]))
                kept = kept + 1;
            prod  = kept;
            shift = shift + drop;
        end
        if (shift >= 0)
            return 32'(prod << shift);
        if (shift <= -64)
            return 32'h0;
        return 32'(prod >> (-shift));
    endfunction

    function automatic logic [31:0] convert_channel(logic [1:0] src, logic [1:0] dst,
                                                    logic [31:0] x);
        if (src == FMT_UNUSED || dst == FMT_UNUSED)
            return 32'h0;
        case (src)
            FMT_U8:
                case (dst)
                    FMT_U8:  return {24'h0, x[7:0]};
                    FMT_U16: return 32'(x[7:0]) * 257;
                    default: return unorm_to_single(32'(x[7:0]), 32'd255);
                endcase
            FMT_U16:
                case (dst)
                    FMT_U8:  return 32'(x[15:0]) / 257;
                    FMT_U16: return {16'h0, x[15:0]};
                    default: return unorm_to_single(32'(x[15:0]), 32'd65535);
                endcase
            default:
                case (dst)
                    FMT_U8:  return single_to_unorm(x, 32'd255);
                    FMT_U16: return single_to_unorm(x, 32'd65535);
                    default: return x;
                endcase
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // input transfers, config writes and result checks
    always @(posedge clk)
    begin
        channel_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_SOURCE)
                    cur_source <= cfg_data;
                else if (cfg_index == REG_TARGET)
                    cur_target <= cfg_data;
            end
            if (start && !busy)
                pending_results.push_back(
                    '{convert_channel(cur_source, cur_target, channel_value), channel_index});
            if (done)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result", converted_value, 32'h0);
                else
                begin
                    want = pending_results.pop_front();
                    if (converted_value !== want.value)
                        report_mismatch("converted_value", converted_value, want.value);
                    if (channel_tag !== want.tag)
                        report_mismatch("channel_tag", 32'(channel_tag), 32'(want.tag));
                end
            end
        end
    end

    // one input transfer, start stays high afterwards
    task automatic send_channel(logic [31:0] value, logic [1:0] index);
        @(negedge clk);
        start         <= 1'b1;
        channel_value <= value;
        channel_index <= index;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic maybe_idle();
        if (!no_idle && $urandom_range(99) < 13)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(3)) @(negedge clk);
        end
    endtask

    // stop sending and wait until all results have come back
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_formats(logic [1:0] src, logic [1:0] dst);
        drain();
        write_register(REG_SOURCE, src);
        write_register(REG_TARGET, dst);
    endtask

    function automatic logic [31:0] random_value(logic [1:0] src);
        logic [31:0] v;
        v = $urandom;
        if (src != FMT_F32)
            return v;
        case ($urandom_range(9))
            0:       return {v[31], 8'hFF, v[22:0]};
            1:       return {v[31], 31'h0};
            2:       return {1'b0, v[30:0] % 31'h3F80_0001};
            3, 4, 5: return {1'b0, 8'($urandom_range(126, 100)), v[22:0]};
            6:       return {1'b0, 8'd127, 23'h0};
            default: return v;
        endcase
    endfunction

    directed_row_t rows[] = '{
        '{FMT_U8,  FMT_U8,  32'hFFFF_FF00, 2'd0, 1'b1, 32'h0000_0000},
        '{FMT_U8,  FMT_U8,  32'h0000_00FF, 2'd3, 1'b1, 32'h0000_00FF},
        '{FMT_U8,  FMT_U16, 32'h0000_00FF, 2'd1, 1'b1, 32'h0000_FFFF},
        '{FMT_U8,  FMT_U16, 32'hFFFF_FF00, 2'd2, 1'b1, 32'h0000_0000},
        '{FMT_U16, FMT_U8,  32'h0000_FFFF, 2'd0, 1'b1, 32'h0000_00FF},
        '{FMT_U16, FMT_U8,  32'hABCD_0101, 2'd1, 1'b0, 32'h0},
        '{FMT_U8,  FMT_F32, 32'h0000_00FF, 2'd2, 1'b1, F32_ONE},
        '{FMT_U8,  FMT_F32, 32'h0000_0000, 2'd3, 1'b1, 32'h0000_0000},
        '{FMT_U16, FMT_F32, 32'h0000_FFFF, 2'd0, 1'b1, F32_ONE},
        '{FMT_U16, FMT_F32, 32'hFFFF_0001, 2'd1, 1'b0, 32'h0},
        '{FMT_F32, FMT_U8,  32'h7FC0_0000, 2'd2, 1'b1, 32'h0000_0000},
        '{FMT_F32, FMT_U8,  32'hFFC0_0001, 2'd3, 1'b1, 32'h0000_0000},
        '{FMT_F32, FMT_U8,  32'h7F80_0000, 2'd0, 1'b1, 32'h0000_00FF},
        '{FMT_F32, FMT_U8,  32'hFF80_0000, 2'd1, 1'b1, 32'h0000_0000},
        '{FMT_F32, FMT_U8,  32'h8000_0000, 2'd2, 1'b1, 32'h0000_0000},
        '{FMT_F32, FMT_U8,  32'hBF80_0000, 2'd3, 1'b1, 32'h0000_0000},
        '{FMT_F32, FMT_U8,  F32_ONE,       2'd0, 1'b1, 32'h0000_00FF},
        '{FMT_F32, FMT_U8,  32'h3F00_0000, 2'd1, 1'b0, 32'h0},
        '{FMT_F32, FMT_U16, F32_ONE,       2'd2, 1'b1, 32'h0000_FFFF},
        '{FMT_F32, FMT_U16, 32'h7F7F_FFFF, 2'd3, 1'b1, 32'h0000_FFFF},
        '{FMT_F32, FMT_U16, 32'h0000_0001, 2'd0, 1'b1, 32'h0000_0000},
        '{FMT_F32, FMT_F32, 32'h7FC0_0001, 2'd1, 1'b1, 32'h7FC0_0001},
        '{FMT_F32, FMT_F32, 32'hFFFF_FFFF, 2'd2, 1'b1, 32'hFFFF_FFFF},
        '{FMT_UNUSED, FMT_U8,  32'h0000_00FF, 2'd3, 1'b1, 32'h0000_0000},
        '{FMT_U8,  FMT_UNUSED, 32'h0000_00FF, 2'd1, 1'b1, 32'h0000_0000}
    };

    // stimulus
    initial
    begin
        logic [1:0] src;
        logic [1:0] dst;
        error_count   = 0;
        no_idle       = 1'b0;
        cur_source    = FMT_U8;
        cur_target    = FMT_U8;
        rst_n         = 1'b0;
        start         = 1'b0;
        channel_value = 32'h0;
        channel_index = 2'd0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_SOURCE;
        cfg_data      = FMT_U8;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table, formats rewritten whenever a row needs others
        foreach (rows[i])
        begin
            if (rows[i].src != cur_source || rows[i].dst != cur_target)
                set_formats(rows[i].src, rows[i].dst);
            if (rows[i].typed
                && rows[i].result !== convert_channel(rows[i].src, rows[i].dst, rows[i].value))
                report_mismatch("table row", rows[i].result,
                                convert_channel(rows[i].src, rows[i].dst, rows[i].value));
            send_channel(rows[i].value, rows[i].index);
        end

        // writes to unused register indexes must be ignored
        drain();
        write_register(2'd2, FMT_UNUSED);
        write_register(2'd3, FMT_UNUSED);
        send_channel(32'h1234_5678, 2'd1);

        // random items, formats changed every few dozen transfers
        src = cur_source;
        dst = cur_target;
        for (int n = 0; n < 600; n++)
        begin
            no_idle = (n >= 200 && n < 350);
            if (n % 40 == 0)
            begin
                src = ($urandom_range(19) == 0) ? FMT_UNUSED : 2'($urandom_range(2));
                dst = ($urandom_range(19) == 0) ? FMT_UNUSED : 2'($urandom_range(2));
                if (n % 120 == 0)
                begin
                    src = FMT_F32;
                    dst = 2'($urandom_range(1));
                end
                set_formats(src, dst);
                if ($urandom_range(3) == 0)
                    write_register(2'($urandom_range(3, 2)), 2'($urandom));
            end
            else if (n == 500)
                drain();
            send_channel(random_value(src), 2'($urandom));
            maybe_idle();
        end

        drain();
        if (error_count == 0)
            $display("color_channel_format_converter_top regression: pass");
        else
            $display("color_channel_format_converter_top regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
